>>> design/hopper_level_monitor_assert.svh
// Assertion macros shared by the hopper level monitor checkers.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef HOPPER_LEVEL_MONITOR_ASSERT_SVH
`define HOPPER_LEVEL_MONITOR_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define HLM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hopper_level_monitor: assertion failed");

// Clocked assertion that also holds across reset.
`define HLM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hopper_level_monitor: reset assertion failed");

`endif

>>> design/hlm_pkg.sv
// Package for the hopper level monitor: widths, constants, register codes,
// controller states and the command and status structs. No dependencies.
package hlm_pkg;

  // Field widths.
  localparam int TIME_W     = 40;
  localparam int AUGER_W    = 32;
  localparam int DIST_W     = 16;
  localparam int PCT_W      = 8;
  localparam int LDIST_W    = 17;
  localparam int USAGE_W    = 48;
  localparam int WLVL_W     = 7;
  localparam int IVAL_W     = 11;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Minutes-to-milliseconds product and the percent divider.
  localparam int MIN_MS_W  = 16;
  localparam int IVAL_MS_W = IVAL_W + MIN_MS_W;
  localparam int NUM_W     = 23;  // (2^16 - 1) * 100 fits in 23 bits
  localparam int CNT_W     = $clog2(NUM_W);

  // Constants.
  localparam logic [TIME_W-1:0]   CHECK_PERIOD_MS = 40'd60000;
  localparam logic [MIN_MS_W-1:0] MS_PER_MIN      = 16'd60000;
  localparam logic [NUM_W-1:0]    PCT_SCALE       = 23'd100;
  localparam logic [NUM_W-1:0]    PCT_MAX         = 23'd100;
  localparam logic [PCT_W-1:0]    PCT_UNKNOWN     = 8'hFF;
  localparam logic [LDIST_W-1:0]  DIST_INVALID    = 17'h1FFFF;
  localparam logic [USAGE_W-1:0]  USAGE_MAX       = 48'hFFFF_FFFF_FFFF;

  // Register reset values.
  localparam logic [DIST_W-1:0] EMPTY_RESET = 16'd2200;
  localparam logic [DIST_W-1:0] FULL_RESET  = 16'd400;
  localparam logic [WLVL_W-1:0] WLVL_RESET  = 7'd25;
  localparam logic [IVAL_W-1:0] WIVAL_RESET = 11'd20;
  localparam logic [RATE_W-1:0] RATE_RESET  = 16'd300;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_PRESENT       = 3'd0,
    REG_EMPTY_DISTANCE       = 3'd1,
    REG_FULL_DISTANCE        = 3'd2,
    REG_WARNING_ENABLE       = 3'd3,
    REG_WARN_THRESHOLD       = 3'd4,
    REG_WARNING_INTERVAL_MIN = 3'd5,
    REG_AUGER_RATE           = 3'd6
  } hlm_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_DIV,
    ST_USAGE,
    ST_WARN
  } hlm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request fields
    logic prep;      // check decision, filtering, auger delta
    logic scale;     // level update, divider load, usage product
    logic div_step;  // one restoring divide step
    logic usage;     // percent from quotient, usage accumulate
    logic finish;    // warning decision, load result register
  } hlm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } hlm_status_t;

endpackage

>>> design/hlm_datapath.sv
// Datapath of the hopper level monitor: configuration registers, state,
// reading filter, restoring percent divider, usage and warning. Uses hlm_pkg.
module hlm_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  hlm_pkg::hlm_cmd_t                cmd,
  output hlm_pkg::hlm_status_t             status,
  input  logic                             cfg_we,
  input  logic [hlm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hlm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [hlm_pkg::TIME_W-1:0]       now_ms,
  input  logic [hlm_pkg::AUGER_W-1:0]      auger_total_ms,
  input  logic                             cooking,
  input  logic                             check_request,
  input  logic                             clear_usage,
  input  logic [hlm_pkg::DIST_W-1:0]       reading_first,
  input  logic [hlm_pkg::DIST_W-1:0]       reading_second,
  input  logic [hlm_pkg::DIST_W-1:0]       reading_third,
  output logic signed [hlm_pkg::PCT_W-1:0]   fill_pct,
  output logic signed [hlm_pkg::LDIST_W-1:0] hopper_distance,
  output logic                             level_measured,
  output logic                             low_warning,
  output logic [hlm_pkg::USAGE_W-1:0]      usage_ug
);
  import hlm_pkg::*;

  // Configuration registers.
  logic                 sensor_present;
  logic [DIST_W-1:0]    empty_distance;
  logic [DIST_W-1:0]    full_distance;
  logic                 warning_enable;
  logic [WLVL_W-1:0]    warn_threshold;
  logic [IVAL_W-1:0]    warning_interval_min;
  logic [RATE_W-1:0]    auger_rate;

  // Captured request fields.
  logic [TIME_W-1:0]    now_r;
  logic [AUGER_W-1:0]   auger_r;
  logic                 cooking_r;
  logic                 check_r;
  logic                 clear_r;
  logic [DIST_W-1:0]    rd1;
  logic [DIST_W-1:0]    rd2;
  logic [DIST_W-1:0]    rd3;

  // Persistent monitor state.
  logic [PCT_W-1:0]     level_pct;
  logic [LDIST_W-1:0]   level_distance;
  logic [TIME_W-1:0]    last_check_time;
  logic [TIME_W-1:0]    last_warn_time;
  logic [AUGER_W-1:0]   last_auger_total;
  logic [USAGE_W-1:0]   usage_estimate;
  logic                 check_pending;

  // Per-request working registers.
  logic                 do_check;
  logic [DIST_W-1:0]    dist_f;
  logic                 have_read;
  logic [AUGER_W-1:0]   delta_r;
  logic [IVAL_MS_W-1:0] ival_ms;
  logic [USAGE_W-1:0]   prod_r;
  logic                 div_used;
  logic [NUM_W-1:0]     div_num;
  logic [DIST_W-1:0]    div_rem;
  logic [DIST_W-1:0]    div_den;
  logic [CNT_W-1:0]     div_count;

  // Combinational intermediates.
  logic [TIME_W:0]      check_sum;
  logic                 due;
  logic [DIST_W-1:0]    filtered;
  logic [1:0]           read_cnt;
  logic [AUGER_W-1:0]   delta;
  logic [IVAL_MS_W-1:0] ival_prod;
  logic                 span_ok;
  logic                 near;
  logic                 need_div;
  logic                 div_last;
  logic [NUM_W-1:0]     num;
  logic [DIST_W:0]      rem_sh;
  logic                 ge;
  logic [USAGE_W:0]     usage_sum;
  logic [USAGE_W-1:0]   prod_next;
  logic [TIME_W:0]      warn_sum;
  logic                 warn;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_present       <= 1'b0;
      empty_distance       <= EMPTY_RESET;
      full_distance        <= FULL_RESET;
      warning_enable       <= 1'b1;
      warn_threshold       <= WLVL_RESET;
      warning_interval_min <= WIVAL_RESET;
      auger_rate           <= RATE_RESET;
    end else if (cfg_we) begin
      case (hlm_reg_t'(cfg_index))
        REG_SENSOR_PRESENT:       sensor_present       <= cfg_data[0];
        REG_EMPTY_DISTANCE:       empty_distance       <= cfg_data[DIST_W-1:0];
        REG_FULL_DISTANCE:        full_distance        <= cfg_data[DIST_W-1:0];
        REG_WARNING_ENABLE:       warning_enable       <= cfg_data[0];
        REG_WARN_THRESHOLD:       warn_threshold       <= cfg_data[WLVL_W-1:0];
        REG_WARNING_INTERVAL_MIN: warning_interval_min <= cfg_data[IVAL_W-1:0];
        REG_AUGER_RATE:           auger_rate           <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request fields when the controller accepts a request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= now_ms;
      auger_r   <= auger_total_ms;
      cooking_r <= cooking;
      check_r   <= check_request;
      clear_r   <= clear_usage;
      rd1       <= reading_first;
      rd2       <= reading_second;
      rd3       <= reading_third;
    end
  end

  // Check decision: a pending or requested check, a usage clear, or the period has elapsed.
  assign check_sum = {1'b0, last_check_time} + {1'b0, CHECK_PERIOD_MS};
  assign due = check_pending || check_r || clear_r || ({1'b0, now_r} > check_sum);

  // Reading filter: median of three, mean of two, or the single valid one.
  always_comb begin
    logic             v1;
    logic             v2;
    logic             v3;
    logic [DIST_W-1:0] m1;
    logic [DIST_W-1:0] m2;
    logic [DIST_W-1:0] m3;
    logic [DIST_W-1:0] lo12;
    logic [DIST_W-1:0] hi12;
    logic [DIST_W-1:0] mid;
    logic [DIST_W-1:0] med;
    logic [DIST_W+1:0] sum3;
    v1   = (rd1 != '0);
    v2   = (rd2 != '0);
    v3   = (rd3 != '0);
    m1   = v1 ? rd1 : '0;
    m2   = v2 ? rd2 : '0;
    m3   = v3 ? rd3 : '0;
    lo12 = (rd1 < rd2) ? rd1 : rd2;
    hi12 = (rd1 > rd2) ? rd1 : rd2;
    mid  = (hi12 < rd3) ? hi12 : rd3;
    med  = (lo12 > mid) ? lo12 : mid;
    sum3 = {2'b00, m1} + {2'b00, m2} + {2'b00, m3};
    read_cnt = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
    case (read_cnt)
      2'd3:    filtered = med;
      2'd2:    filtered = sum3[DIST_W:1];
      2'd1:    filtered = m1 | m2 | m3;
      default: filtered = '0;
    endcase
  end

  // Auger delta; a lower total re-bases and adds nothing.
  assign delta     = (auger_r > last_auger_total) ? (auger_r - last_auger_total) : '0;
  assign ival_prod = IVAL_MS_W'(warning_interval_min) * IVAL_MS_W'(MS_PER_MIN);

  // Scaling terms for the percent.
  assign span_ok   = (empty_distance > full_distance);
  assign near      = (dist_f < empty_distance);
  assign num       = NUM_W'(empty_distance - dist_f) * PCT_SCALE;
  assign prod_next = USAGE_W'(delta_r) * USAGE_W'(auger_rate);

  assign need_div = do_check && sensor_present && have_read && span_ok && near;
  assign div_last = (div_count == '0);
  assign status   = '{need_div: need_div, div_last: div_last};

  // One restoring divide step.
  assign rem_sh = {div_rem, div_num[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_den});

  // Saturating usage accumulation.
  assign usage_sum = {1'b0, usage_estimate} + {1'b0, prod_r};

  // Low level warning, rate limited by the interval.
  assign warn_sum = {1'b0, last_warn_time} + (TIME_W + 1)'(ival_ms);
  assign warn = cooking_r && !level_pct[PCT_W-1] && warning_enable &&
                (level_pct[WLVL_W-1:0] <= warn_threshold) && ({1'b0, now_r} > warn_sum);

  // Working registers for one request.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      do_check  <= due;
      dist_f    <= filtered;
      have_read <= (read_cnt != 2'd0);
      delta_r   <= delta;
      ival_ms   <= ival_prod;
    end
    if (cmd.scale) begin
      prod_r    <= prod_next;
      div_used  <= need_div;
      div_num   <= num;
      div_rem   <= '0;
      div_den   <= empty_distance - full_distance;
      div_count <= CNT_W'(NUM_W - 1);
    end
    if (cmd.div_step) begin
      div_rem   <= ge ? DIST_W'(rem_sh - {1'b0, div_den}) : rem_sh[DIST_W-1:0];
      div_num   <= {div_num[NUM_W-2:0], ge};
      div_count <= div_count - 1'b1;
    end
  end

  // Check bookkeeping and auger re-base.
  always_ff @(posedge clk) begin
    if (rst) begin
      check_pending    <= 1'b1;
      last_check_time  <= '0;
      last_auger_total <= '0;
    end else if (cmd.prep) begin
      // Any pending check is served in this request.
      check_pending <= 1'b0;
      if (due) begin
        last_check_time <= now_r;
      end
      if (auger_r != last_auger_total) begin
        last_auger_total <= auger_r;
      end
    end
  end

  // Level state and usage estimate.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_pct      <= PCT_UNKNOWN;
      level_distance <= DIST_INVALID;
      usage_estimate <= '0;
    end else begin
      if (cmd.prep && clear_r) begin
        usage_estimate <= '0;
      end
      if (cmd.scale && do_check) begin
        if (!sensor_present) begin
          level_pct <= PCT_UNKNOWN;
        end else if (!have_read || !span_ok) begin
          level_pct      <= PCT_UNKNOWN;
          level_distance <= DIST_INVALID;
        end else begin
          level_distance <= {1'b0, dist_f};
          if (!near) begin
            level_pct <= '0;
          end
        end
      end
      if (cmd.usage) begin
        if (div_used) begin
          level_pct <= (div_num > PCT_MAX) ? PCT_MAX[PCT_W-1:0] : div_num[PCT_W-1:0];
        end
        usage_estimate <= usage_sum[USAGE_W] ? USAGE_MAX : usage_sum[USAGE_W-1:0];
      end
    end
  end

  // Warning time stamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_warn_time <= '0;
    end else if (cmd.finish && warn) begin
      last_warn_time <= now_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      fill_pct        <= level_pct;
      hopper_distance <= level_distance;
      level_measured  <= do_check;
      low_warning     <= warn;
      usage_ug        <= usage_estimate;
    end
  end

endmodule

>>> design/hlm_ctrl.sv
// Controller of the hopper level monitor: sequences one request through the
// datapath and owns the request and result handshakes. Uses hlm_pkg.
module hlm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 cfg_ready,
  output hlm_pkg::hlm_cmd_t    cmd,
  input  hlm_pkg::hlm_status_t status
);
  import hlm_pkg::*;

  hlm_state_t state;
  hlm_state_t state_next;
  logic       out_free;

  // The result register can be loaded when it is empty or being taken.
  assign out_free = !result_valid || !result_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:  state_next = ST_SCALE;
      ST_SCALE: state_next = status.need_div ? ST_DIV : ST_USAGE;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_USAGE;
        end
      end
      ST_USAGE: state_next = ST_WARN;
      ST_WARN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    cfg_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cfg_ready  = 1'b1;
        cmd.load   = item_valid;
      end
      ST_PREP:  cmd.prep     = 1'b1;
      ST_SCALE: cmd.scale    = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_USAGE: cmd.usage    = 1'b1;
      ST_WARN:  cmd.finish   = out_free;
      default: ;
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> design/hopper_level_monitor.sv
// Hopper level monitor: a request passes through the prep, scale, usage and
// warning states, with the 23-step restoring divider between scale and usage
// when a percent divide is needed. One request is in flight at a time: the
// next request is taken the cycle after the result is loaded.
// Synchronous reset loads the register defaults, marks the level unknown and
// leaves a level check pending; there is no clearing pass.
module hopper_level_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [hlm_pkg::TIME_W-1:0]       now_ms,
  input  logic [hlm_pkg::AUGER_W-1:0]      auger_total_ms,
  input  logic                             cooking,
  input  logic                             check_request,
  input  logic                             clear_usage,
  input  logic [hlm_pkg::DIST_W-1:0]       reading_first,
  input  logic [hlm_pkg::DIST_W-1:0]       reading_second,
  input  logic [hlm_pkg::DIST_W-1:0]       reading_third,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [hlm_pkg::PCT_W-1:0]   fill_pct,
  output logic signed [hlm_pkg::LDIST_W-1:0] hopper_distance,
  output logic                             level_measured,
  output logic                             low_warning,
  output logic [hlm_pkg::USAGE_W-1:0]      usage_ug,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hlm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hlm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hlm_pkg::*;

  hlm_cmd_t    cmd;
  hlm_status_t status;
  logic        cfg_we;

  // A configuration write completes on valid and ready.
  assign cfg_we = cfg_valid && cfg_ready;

  // Sequencer.
  hlm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Arithmetic and state.
  hlm_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .now_ms          (now_ms),
    .auger_total_ms  (auger_total_ms),
    .cooking         (cooking),
    .check_request   (check_request),
    .clear_usage     (clear_usage),
    .reading_first   (reading_first),
    .reading_second  (reading_second),
    .reading_third   (reading_third),
    .fill_pct        (fill_pct),
    .hopper_distance (hopper_distance),
    .level_measured  (level_measured),
    .low_warning     (low_warning),
    .usage_ug        (usage_ug)
  );

endmodule

>>> design/hlm_checker.sv
// Port-level checker for the hopper level monitor and its bind statement.
// Depends on hopper_level_monitor_assert.svh for the assertion macros.
`include "hopper_level_monitor_assert.svh"

module hlm_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [7:0]  fill_pct,
  input logic [47:0]        usage_ug
);

  // Reset leaves the block idle with no result shown.
  `HLM_ASSERT_RST(a_reset_idle, rst |=> (!result_valid && !item_stall))

  // One request at a time: the block is busy right after taking one.
  `HLM_ASSERT(a_busy_after_accept, (item_valid && !item_stall) |=> item_stall)

  // A result taken while the block is idle is not followed by another.
  `HLM_ASSERT(a_gap_after_result, (result_valid && !result_stall && !item_stall) |=> !result_valid)

  // The percent is unknown or within 0 to 100.
  `HLM_ASSERT(a_pct_range, result_valid |-> ((fill_pct >= -8'sd1) && (fill_pct <= 8'sd100)))

  // A stalled result holds.
  `HLM_ASSERT(a_hold, (result_valid && result_stall) |=> $stable({result_valid, fill_pct, usage_ug}))

endmodule

bind hopper_level_monitor hlm_checker u_hlm_checker (.*);

>>> test/tb.sv
// Self-checking testbench for hopper_level_monitor: directed and random ticks,
// register phases, random idling on both sides. Depends on hlm_pkg and the block.
`timescale 1ns / 1ps

module tb;
  import hlm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // One tick as the sender presents it.
  typedef struct packed {
    logic [TIME_W-1:0]  now;
    logic [AUGER_W-1:0] auger;
    logic               cook;
    logic               chk;
    logic               clr;
    logic [DIST_W-1:0]  r1;
    logic [DIST_W-1:0]  r2;
    logic [DIST_W-1:0]  r3;
    logic               drain_first;
  } tick_t;

  // Expected level report for one tick.
  typedef struct {
    logic signed [PCT_W-1:0]   pct;
    logic signed [LDIST_W-1:0] distance;
    logic                      meas;
    logic                      warn;
    logic [USAGE_W-1:0]        usage;
  } level_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  item_valid     = 1'b0;
  logic                  item_stall;
  logic [TIME_W-1:0]     now_ms         = '0;
  logic [AUGER_W-1:0]    auger_total_ms = '0;
  logic                  cooking        = 1'b0;
  logic                  check_request  = 1'b0;
  logic                  clear_usage    = 1'b0;
  logic [DIST_W-1:0]     reading_first  = '0;
  logic [DIST_W-1:0]     reading_second = '0;
  logic [DIST_W-1:0]     reading_third  = '0;
  logic                  result_valid;
  logic                  result_stall   = 1'b0;
  logic signed [PCT_W-1:0]   fill_pct;
  logic signed [LDIST_W-1:0] hopper_distance;
  logic                  level_measured;
  logic                  low_warning;
  logic [USAGE_W-1:0]    usage_ug;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // Register copies kept by the predictor.
  logic              cf_sensor = 1'b0;
  logic [DIST_W-1:0] cf_empty  = EMPTY_RESET;
  logic [DIST_W-1:0] cf_full   = FULL_RESET;
  logic              cf_wen    = 1'b1;
  logic [WLVL_W-1:0] cf_wlvl   = WLVL_RESET;
  logic [IVAL_W-1:0] cf_ival   = WIVAL_RESET;
  logic [RATE_W-1:0] cf_rate   = RATE_RESET;

  // Monitor state kept by the predictor.
  logic signed [PCT_W-1:0]   lvl_pct     = PCT_UNKNOWN;
  logic signed [LDIST_W-1:0] lvl_dist    = DIST_INVALID;
  logic [TIME_W-1:0]         last_check  = '0;
  logic [TIME_W-1:0]         last_warn   = '0;
  logic [AUGER_W-1:0]        last_auger  = '0;
  logic [USAGE_W-1:0]        usage_est   = '0;
  logic                      chk_pending = 1'b1;

  tick_t      tick_q[$];
  level_rec_t level_exp[$];
  tick_t      cur_tick;
  level_rec_t got_rec;

  logic tick_taken = 1'b0;
  logic res_taken  = 1'b0;
  int   send_gap   = 0;
  int   rcv_wait   = 0;
  int   hold_left  = 0;
  int   res_count  = 0;
  int   fail_cnt   = 0;
  int   idle_max   = 16;

  // Stimulus generator position in time and auger on-time.
  logic [TIME_W-1:0]  t_now   = '0;
  logic [AUGER_W-1:0] t_auger = '0;

  hopper_level_monitor u_top (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .now_ms          (now_ms),
    .auger_total_ms  (auger_total_ms),
    .cooking         (cooking),
    .check_request   (check_request),
    .clear_usage     (clear_usage),
    .reading_first   (reading_first),
    .reading_second  (reading_second),
    .reading_third   (reading_third),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .fill_pct        (fill_pct),
    .hopper_distance (hopper_distance),
    .level_measured  (level_measured),
    .low_warning     (low_warning),
    .usage_ug        (usage_ug),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the level report for the tick on the input ports and queues it.
  task automatic predict_level();
    logic [DIST_W-1:0] v0, v1, v2, lo, hi, mid, filt;
    int n;
    logic [63:0] wide_a, wide_b, quot, prod, total, warn_at;
    level_rec_t rec;
    n = 0;
    v0 = '0;
    v1 = '0;
    v2 = '0;
    rec.meas = 1'b0;
    rec.warn = 1'b0;

    // A new pellet load or a request leaves a check pending for this tick.
    if (clear_usage) begin
      usage_est = '0;
      chk_pending = 1'b1;
    end
    if (check_request) chk_pending = 1'b1;

    // Gather the nonzero readings in order, then filter them.
    if (reading_first != 0) begin
      v0 = reading_first;
      n = 1;
    end
    if (reading_second != 0) begin
      if (n == 0) v0 = reading_second;
      else v1 = reading_second;
      n++;
    end
    if (reading_third != 0) begin
      if (n == 0) v0 = reading_third;
      else if (n == 1) v1 = reading_third;
      else v2 = reading_third;
      n++;
    end
    lo  = (v0 < v1) ? v0 : v1;
    hi  = (v0 < v1) ? v1 : v0;
    mid = (hi < v2) ? hi : v2;
    if (n == 3) filt = (lo > mid) ? lo : mid;
    else if (n == 2) filt = 16'(({1'b0, v0} + {1'b0, v1}) >> 1);
    else filt = v0;

    // Level check on a pending request or after the check period.
    wide_a = now_ms;
    wide_b = last_check;
    if (chk_pending || wide_a > wide_b + CHECK_PERIOD_MS) begin
      chk_pending = 1'b0;
      last_check = now_ms;
      rec.meas = 1'b1;
      if (!cf_sensor) begin
        lvl_pct = PCT_UNKNOWN;
      end else if (n == 0 || cf_empty <= cf_full) begin
        lvl_pct = PCT_UNKNOWN;
        lvl_dist = DIST_INVALID;
      end else begin
        lvl_dist = {1'b0, filt};
        if (filt >= cf_empty) begin
          lvl_pct = '0;
        end else begin
          wide_a = cf_empty - filt;
          wide_b = cf_empty - cf_full;
          quot = (wide_a * 100) / wide_b;
          lvl_pct = (quot > 100) ? 8'd100 : quot[7:0];
        end
      end
    end

    // Usage grows with the auger delta; a lower total starts a new cook.
    if (auger_total_ms < last_auger) last_auger = auger_total_ms;
    if (auger_total_ms > last_auger) begin
      wide_a = auger_total_ms - last_auger;
      prod = wide_a * cf_rate;
      last_auger = auger_total_ms;
      total = usage_est + prod;
      usage_est = (total > USAGE_MAX) ? USAGE_MAX : total[USAGE_W-1:0];
    end

    // Low level warning, at most once per interval.
    wide_a = now_ms;
    wide_b = cf_ival;
    warn_at = last_warn + wide_b * MS_PER_MIN;
    if (cooking && !lvl_pct[PCT_W-1] && cf_wen && lvl_pct[6:0] <= cf_wlvl &&
        wide_a > warn_at) begin
      last_warn = now_ms;
      rec.warn = 1'b1;
    end

    rec.pct = lvl_pct;
    rec.distance = lvl_dist;
    rec.usage = usage_est;
    level_exp.push_back(rec);
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t ns: %s expected %0d got %0d", $time, fname, want, got);
    end
  endtask

  // Input side: predict on every accepted request.
  always @(posedge clk) begin
    tick_taken <= !rst && item_valid && !item_stall;
    if (!rst && item_valid && !item_stall) predict_level();
  end

  // Sender: presents queued requests with a random gap after each accepted one.
  always @(negedge clk) begin
    if (tick_taken) send_gap = $urandom_range(idle_max, 0);
    if (!rst && (!item_valid || tick_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (tick_q.size() != 0 &&
                   (!tick_q[0].drain_first || level_exp.size() == 0)) begin
        cur_tick = tick_q.pop_front();
        item_valid     <= 1'b1;
        now_ms         <= cur_tick.now;
        auger_total_ms <= cur_tick.auger;
        cooking        <= cur_tick.cook;
        check_request  <= cur_tick.chk;
        clear_usage    <= cur_tick.clr;
        reading_first  <= cur_tick.r1;
        reading_second <= cur_tick.r2;
        reading_third  <= cur_tick.r3;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Output side: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_taken <= !rst && result_valid && !result_stall;
    if (!rst && result_valid && !result_stall) begin
      res_count++;
      if (level_exp.size() == 0) begin
        fail_cnt++;
        $display("%0t ns: result with no request waiting, expected none got pct %0d",
                 $time, fill_pct);
      end else begin
        got_rec = level_exp.pop_front();
        check_field("fill_pct", got_rec.pct, fill_pct);
        check_field("hopper_distance", got_rec.distance, hopper_distance);
        check_field("level_measured", got_rec.meas, level_measured);
        check_field("low_warning", got_rec.warn, low_warning);
        check_field("usage_ug", got_rec.usage, usage_ug);
      end
    end
  end

  // Receiver: holds each result a random number of cycles, and twice holds off
  // for a long stretch so the block backs up into its input.
  always @(negedge clk) begin
    if (res_taken) begin
      rcv_wait = $urandom_range(idle_max, 0);
      if (res_count == 300 || res_count == 1000) hold_left = 250;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (rcv_wait > 0) begin
      if (result_valid) rcv_wait--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SENSOR_PRESENT:       cf_sensor = val[0];
      REG_EMPTY_DISTANCE:       cf_empty  = val;
      REG_FULL_DISTANCE:        cf_full   = val;
      REG_WARNING_ENABLE:       cf_wen    = val[0];
      REG_WARN_THRESHOLD:       cf_wlvl   = val[WLVL_W-1:0];
      REG_WARNING_INTERVAL_MIN: cf_ival   = val[IVAL_W-1:0];
      REG_AUGER_RATE:           cf_rate   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_regs(input logic sensor, input logic [15:0] e_d, input logic [15:0] f_d,
                            input logic en, input logic [15:0] lvl, input logic [15:0] ival,
                            input logic [15:0] rate);
    write_reg(REG_SENSOR_PRESENT, {15'd0, sensor});
    write_reg(REG_EMPTY_DISTANCE, e_d);
    write_reg(REG_FULL_DISTANCE, f_d);
    write_reg(REG_WARNING_ENABLE, {15'd0, en});
    write_reg(REG_WARN_THRESHOLD, lvl);
    write_reg(REG_WARNING_INTERVAL_MIN, ival);
    write_reg(REG_AUGER_RATE, rate);
  endtask

  // Waits until every queued request has been sent and answered.
  task automatic settle();
    while (tick_q.size() != 0 || item_valid || level_exp.size() != 0) @(posedge clk);
  endtask

  task automatic push_tick(input logic [TIME_W-1:0] now, input logic [AUGER_W-1:0] auger,
                           input logic cook, input logic chk, input logic clr,
                           input logic [DIST_W-1:0] r1, input logic [DIST_W-1:0] r2,
                           input logic [DIST_W-1:0] r3);
    tick_t tk;
    tk.now = now;
    tk.auger = auger;
    tk.cook = cook;
    tk.chk = chk;
    tk.clr = clr;
    tk.r1 = r1;
    tk.r2 = r2;
    tk.r3 = r3;
    tk.drain_first = 1'b0;
    tick_q.push_back(tk);
  endtask

  // Readings mostly fall around the configured span, sometimes missing or wild.
  function automatic logic [DIST_W-1:0] pick_reading(input logic [15:0] e_d,
                                                     input logic [15:0] f_d);
    int unsigned lo, hi, sel;
    sel = $urandom_range(99, 0);
    lo = (e_d < f_d) ? e_d : f_d;
    hi = (e_d < f_d) ? f_d : e_d;
    lo = (lo > 200) ? lo - 200 : 1;
    hi = (hi < 65335) ? hi + 200 : 65535;
    if (sel < 20) return '0;
    else if (sel < 85) return 16'($urandom_range(hi, lo));
    else return 16'($urandom);
  endfunction

  // Mostly a running clock and a growing auger total; now and then the clock
  // steps back or jumps, and the auger total drops for a new cook.
  task automatic push_random(input int count);
    tick_t tk;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(199, 0);
      if (sel < 140) t_now = t_now + $urandom_range(3000, 0);
      else if (sel < 175) t_now = t_now + $urandom_range(200000, 60000);
      else if (sel < 194) t_now = t_now + $urandom_range(3000000, 200000);
      else if (sel < 198)
        t_now = (t_now > 100000) ? t_now - $urandom_range(100000, 1)
                                 : 40'($urandom_range(1000, 0));
      else t_now = 40'({$urandom, $urandom});
      sel = $urandom_range(99, 0);
      if (sel < 80) t_auger = t_auger + $urandom_range(2000, 0);
      else if (sel < 86) t_auger = t_auger;
      else if (sel < 95) t_auger = $urandom_range(t_auger, 0);
      else t_auger = $urandom;
      tk.now = t_now;
      tk.auger = t_auger;
      tk.cook = ($urandom_range(9, 0) < 7);
      tk.chk = ($urandom_range(99, 0) < 15);
      tk.clr = ($urandom_range(99, 0) < 3);
      tk.r1 = pick_reading(cf_empty, cf_full);
      tk.r2 = pick_reading(cf_empty, cf_full);
      tk.r3 = pick_reading(cf_empty, cf_full);
      tk.drain_first = (i == count / 2) || ($urandom_range(99, 0) == 0);
      tick_q.push_back(tk);
    end
  endtask

  // Run sequence: reset, directed ticks, then register phases of random ticks.
  initial begin
    logic [15:0] rnd_empty;
    logic [15:0] rnd_full;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No sensor after reset: the pending check runs but the level stays unknown.
    push_tick(40'd0, 32'd0, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd1000, 16'd1000);
    push_tick(40'd60000, 32'd100, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd0, 16'd0);
    push_tick(40'd60001, 32'd200, 1'b1, 1'b0, 1'b0, 16'd1000, 16'd0, 16'd0);
    settle();
    setup_regs(1'b1, 16'd2200, 16'd400, 1'b1, 16'd25, 16'd0, 16'd300);

    // Filtering: single, mean of two rounded down, median, none valid.
    push_tick(40'd70000, 32'd300, 1'b0, 1'b1, 1'b0, 16'd1000, 16'd0, 16'd0);
    push_tick(40'd70001, 32'd400, 1'b0, 1'b1, 1'b0, 16'd1000, 16'd1001, 16'd0);
    push_tick(40'd70002, 32'd500, 1'b0, 1'b1, 1'b0, 16'd0, 16'd1500, 16'd901);
    push_tick(40'd70003, 32'd600, 1'b0, 1'b1, 1'b0, 16'd1800, 16'd500, 16'd2100);
    push_tick(40'd70004, 32'd600, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
    // Percent limits: beyond empty, above full, exactly full.
    push_tick(40'd70005, 32'd700, 1'b0, 1'b1, 1'b0, 16'd2200, 16'd2300, 16'd2250);
    push_tick(40'd70006, 32'd700, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_tick(40'd70007, 32'd800, 1'b0, 1'b1, 1'b0, 16'd100, 16'd100, 16'd100);
    push_tick(40'd70008, 32'd800, 1'b0, 1'b1, 1'b0, 16'd400, 16'd0, 16'd0);
    // Low level while cooking fires, then not again at the same time.
    push_tick(40'd70009, 32'd900, 1'b1, 1'b1, 1'b0, 16'd2150, 16'd0, 16'd0);
    push_tick(40'd70009, 32'd900, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
    // New pellet load zeroes usage and forces a check.
    push_tick(40'd70010, 32'd1000, 1'b1, 1'b0, 1'b1, 16'd2150, 16'd2150, 16'd0);
    // Clock steps back, then a lower auger total starts a new cook.
    push_tick(40'd5, 32'd1100, 1'b1, 1'b0, 1'b0, 16'd1200, 16'd0, 16'd0);
    push_tick(40'd6, 32'd50, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
    settle();

    // An index past the list is ignored; the largest rate drives saturation.
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_AUGER_RATE, 16'hFFFF);
    push_tick(40'd10, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
    push_tick(40'd11, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
    push_tick(40'd12, 32'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
    push_tick(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0,
              16'hFFFF, 16'd1, 16'h8000);
    push_tick(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
              16'd1, 16'd1, 16'd1);
    t_now = '0;
    t_auger = '0;

    // Register phases with random ticks.
    settle();
    setup_regs(1'b1, 16'd2200, 16'd400, 1'b1, 16'd25, 16'd0, 16'd300);
    idle_max = 16;
    push_random(250);
    settle();
    setup_regs(1'b1, 16'hFFFF, 16'd0, 1'b1, 16'd100, 16'd1, 16'hFFFF);
    idle_max = 0;
    push_random(250);
    settle();
    setup_regs(1'b1, 16'd1000, 16'd1000, 1'b1, 16'd0, 16'd1440, 16'd0);
    idle_max = 16;
    push_random(200);
    settle();
    setup_regs(1'b1, 16'd500, 16'd3000, 1'b1, 16'd25, 16'd20, 16'd300);
    push_random(100);
    settle();
    setup_regs(1'b0, 16'd3000, 16'd200, 1'b1, 16'd50, 16'd0, 16'd1);
    idle_max = 8;
    push_random(150);
    settle();
    setup_regs(1'b1, 16'd2200, 16'd400, 1'b0, 16'd100, 16'd0, 16'd300);
    idle_max = 16;
    push_random(150);

    // Random register contents, including bits above each register's width.
    for (int k = 0; k < 3; k++) begin
      settle();
      rnd_empty = $urandom;
      rnd_full = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(rnd_empty, 0));
      write_reg(REG_SENSOR_PRESENT, ($urandom_range(3, 0) != 0) ? (16'($urandom) | 16'd1)
                                                               : (16'($urandom) & 16'hFFFE));
      write_reg(REG_EMPTY_DISTANCE, rnd_empty);
      write_reg(REG_FULL_DISTANCE, rnd_full);
      write_reg(REG_WARNING_ENABLE, 16'($urandom));
      write_reg(REG_WARN_THRESHOLD, 16'($urandom));
      write_reg(REG_WARNING_INTERVAL_MIN, ($urandom_range(1, 0) != 0) ? 16'($urandom_range(2, 0))
                                                                     : 16'($urandom));
      write_reg(REG_AUGER_RATE, 16'($urandom));
      write_reg(REG_NONE, 16'($urandom));
      push_random(150);
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && level_exp.size() == 0) begin
      $display("PASS hopper_level_monitor");
    end else begin
      $display("FAIL hopper_level_monitor");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAIL hopper_level_monitor");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/hlm_pkg.sv
design/hlm_datapath.sv
design/hlm_ctrl.sv
design/hopper_level_monitor.sv
design/hlm_checker.sv
test/tb.sv
